// ===== sv/dotq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the deadline-ordered timer queue.
// No dependencies; every other file imports this package.
package dotq_pkg;

    localparam int TIME_W  = 48;
    localparam int IVAL_W  = 32;
    localparam int ID_W    = 8;
    localparam int STALE_W = 16;
    localparam logic [STALE_W-1:0] STALE_RESET = 16'd100;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_INS,
        S_CANCEL,
        S_FIRE,
        S_RLOAD,
        S_RINS,
        S_CLOSE
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_in;
        logic load_fq;
        logic insert;
        logic cancel;
        logic pop_fire;
        logic emit_close;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic out_free;
        logic head_due;
        logic fq_empty;
    } t_sts;

endpackage

// ===== sv/dotq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the timer queue.
// Depends on dotq_pkg; drives commands into dotq_dp.
module dotq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dotq_pkg::t_sts i_sts,
    output dotq_pkg::t_cmd o_cmd
);
    import dotq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CLOSE;
                end
            end
            S_PREP:   n_state = S_INS;
            S_INS:    n_state = S_CLOSE;
            S_CANCEL: n_state = S_CLOSE;
            S_FIRE: begin
                if (!i_sts.head_due) begin
                    n_state = i_sts.fq_empty ? S_CLOSE : S_RLOAD;
                end
            end
            S_RLOAD:  n_state = S_RINS;
            S_RINS:   n_state = i_sts.fq_empty ? S_CLOSE : S_RLOAD;
            S_CLOSE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && i_in_valid) begin
            case (i_sts.op)
                OP_ADD:    n_state = S_PREP;
                OP_CANCEL: n_state = S_CANCEL;
                OP_TICK:   n_state = S_FIRE;
                default:   n_state = S_CLOSE;
            endcase
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_PREP:   o_cmd.load_in = 1'b1;
            S_INS:    o_cmd.insert = 1'b1;
            S_CANCEL: o_cmd.cancel = 1'b1;
            S_FIRE:   o_cmd.pop_fire = i_sts.head_due && i_sts.out_free;
            S_RLOAD:  o_cmd.load_fq = 1'b1;
            S_RINS:   o_cmd.insert = 1'b1;
            S_CLOSE:  o_cmd.emit_close = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/dotq_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the timer queue: sorted cell chain, refire queue, output register.
// Depends on dotq_pkg; driven by dotq_ctrl.
module dotq_dp #(
    parameter int SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dotq_pkg::t_cmd                i_cmd,
    output dotq_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [dotq_pkg::STALE_W-1:0]  i_cfg_wdata,
    input  logic [1:0]                    i_op,
    input  logic [dotq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [dotq_pkg::IVAL_W-1:0]   i_interval_ms,
    input  logic                          i_repeat_req,
    input  logic [dotq_pkg::TIME_W-1:0]   i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [dotq_pkg::ID_W-1:0]     o_fired_id,
    output logic [1:0]                    o_status,
    output logic [dotq_pkg::IVAL_W-1:0]   o_next_wake_ms,
    output logic                          o_wake_pending,
    output logic                          o_last
);
    import dotq_pkg::*;

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [STALE_W-1:0] r_stale;
    logic [1:0]         r_op;
    logic [ID_W-1:0]    r_id;
    logic [IVAL_W-1:0]  r_iv;
    logic               r_rep;
    logic [TIME_W-1:0]  r_now;
    logic [1:0]         r_status;

    logic [TIME_W-1:0]  r_ins_dl;
    logic [IVAL_W-1:0]  r_ins_per;
    logic [ID_W-1:0]    r_ins_id;
    logic               r_ins_rep;

    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [TIME_W-1:0]  r_dl [SLOTS];
    logic [TIME_W-1:0]  n_dl [SLOTS];
    logic [IVAL_W-1:0]  r_per [SLOTS];
    logic [IVAL_W-1:0]  n_per [SLOTS];
    logic [ID_W-1:0]    r_cid [SLOTS];
    logic [ID_W-1:0]    n_cid [SLOTS];
    logic [SLOTS-1:0]   r_crep, n_crep;

    logic [ID_W-1:0]    r_fq_id [SLOTS];
    logic [IVAL_W-1:0]  r_fq_per [SLOTS];
    logic [PW-1:0]      r_fq_wr, r_fq_rd;
    logic [CW-1:0]      r_fq_cnt;

    logic [SLOTS-1:0]   le, hit, prior;
    logic               full;
    logic               out_free;
    logic               head_due;
    logic [TIME_W-1:0]  sel_now_base;
    logic [IVAL_W-1:0]  sel_per;
    logic [TIME_W:0]    dl_sum;
    logic [TIME_W-1:0]  dl_sat;
    logic [TIME_W-1:0]  diff;
    logic [IVAL_W-1:0]  wake;

    assign full     = r_valid[SLOTS-1];
    assign out_free = !o_out_valid || !i_out_stall;
    assign head_due = r_valid[0] && (r_dl[0] <= r_now);

    assign o_sts.op       = t_op'(r_op);
    assign o_sts.out_free = out_free;
    assign o_sts.head_due = head_due;
    assign o_sts.fq_empty = (r_fq_cnt == '0);

    assign sel_per      = i_cmd.load_fq ? r_fq_per[r_fq_rd] : r_iv;
    assign sel_now_base = r_now;
    assign dl_sum       = {1'b0, sel_now_base} + {{(TIME_W + 1 - IVAL_W){1'b0}}, sel_per};
    assign dl_sat       = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

    assign diff = r_dl[0] - r_now;
    always_comb begin
        if (!r_valid[0]) begin
            wake = '0;
        end else if (r_dl[0] > r_now) begin
            wake = (diff[TIME_W-1:IVAL_W] != '0) ? {IVAL_W{1'b1}} : diff[IVAL_W-1:0];
        end else begin
            wake = {{(IVAL_W - STALE_W){1'b0}}, r_stale};
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            le[i]  = r_valid[i] && (r_dl[i] <= r_ins_dl);
            hit[i] = r_valid[i] && (r_cid[i] == r_id);
        end
        prior[0] = 1'b0;
        for (int i = 1; i < SLOTS; i++) begin
            prior[i] = prior[i-1] | hit[i-1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_crep  = r_crep;
        for (int i = 0; i < SLOTS; i++) begin
            n_dl[i]  = r_dl[i];
            n_per[i] = r_per[i];
            n_cid[i] = r_cid[i];
        end
        if (i_cmd.insert && !full) begin
            n_valid = {r_valid[SLOTS-2:0], 1'b1};
            for (int i = 0; i < SLOTS; i++) begin
                if (!le[i]) begin
                    if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
                        n_dl[i]   = r_ins_dl;
                        n_per[i]  = r_ins_per;
                        n_cid[i]  = r_ins_id;
                        n_crep[i] = r_ins_rep;
                    end else begin
                        n_dl[i]   = r_dl[(i == 0) ? 0 : i-1];
                        n_per[i]  = r_per[(i == 0) ? 0 : i-1];
                        n_cid[i]  = r_cid[(i == 0) ? 0 : i-1];
                        n_crep[i] = r_crep[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end else if (i_cmd.pop_fire || (i_cmd.cancel && (hit != '0))) begin
            n_valid = {1'b0, r_valid[SLOTS-1:1]};
            for (int i = 0; i < SLOTS - 1; i++) begin
                if (i_cmd.pop_fire || prior[i] || hit[i]) begin
                    n_dl[i]   = r_dl[i+1];
                    n_per[i]  = r_per[i+1];
                    n_cid[i]  = r_cid[i+1];
                    n_crep[i] = r_crep[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crep <= n_crep;
        for (int i = 0; i < SLOTS; i++) begin
            r_dl[i]  <= n_dl[i];
            r_per[i] <= n_per[i];
            r_cid[i] <= n_cid[i];
        end
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_id  <= i_timer_id;
            r_iv  <= i_interval_ms;
            r_rep <= i_repeat_req;
            r_now <= i_now_ms;
        end
        if (i_cmd.load_in || i_cmd.load_fq) begin
            r_ins_dl  <= dl_sat;
            r_ins_per <= sel_per;
            r_ins_id  <= i_cmd.load_fq ? r_fq_id[r_fq_rd] : r_id;
            r_ins_rep <= i_cmd.load_fq ? 1'b1 : r_rep;
        end
        if (i_cmd.pop_fire && r_crep[0]) begin
            r_fq_id[r_fq_wr]  <= r_cid[0];
            r_fq_per[r_fq_wr] <= r_per[0];
        end
        if (i_cmd.pop_fire || i_cmd.emit_close) begin
            o_kind         <= i_cmd.emit_close ? KIND_CLOSE : KIND_FIRED;
            o_fired_id     <= i_cmd.emit_close ? '0 : r_cid[0];
            o_status       <= i_cmd.emit_close ? r_status : ST_OK;
            o_next_wake_ms <= i_cmd.emit_close ? wake : '0;
            o_wake_pending <= i_cmd.emit_close ? r_valid[0] : 1'b0;
            o_last         <= i_cmd.emit_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale     <= STALE_RESET;
            r_valid     <= '0;
            r_fq_wr     <= '0;
            r_fq_rd     <= '0;
            r_fq_cnt    <= '0;
            r_status    <= ST_OK;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stale <= i_cfg_wdata;
            end
            r_valid <= n_valid;
            if (i_cmd.capture) begin
                r_status <= ST_OK;
            end else if (i_cmd.insert && full) begin
                r_status <= ST_FULL;
            end else if (i_cmd.cancel && (hit == '0)) begin
                r_status <= ST_NOTFOUND;
            end
            if (i_cmd.pop_fire && r_crep[0]) begin
                r_fq_wr  <= (r_fq_wr == PW'(SLOTS - 1)) ? '0 : r_fq_wr + 1'b1;
                r_fq_cnt <= r_fq_cnt + 1'b1;
            end else if (i_cmd.load_fq) begin
                r_fq_rd  <= (r_fq_rd == PW'(SLOTS - 1)) ? '0 : r_fq_rd + 1'b1;
                r_fq_cnt <= r_fq_cnt - 1'b1;
            end
            if (i_cmd.pop_fire || i_cmd.emit_close) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid & (r_valid + 1'b1)) == '0)
        else $error("queue valid bits are not a prefix");

    a_fq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fq_cnt <= CW'(SLOTS))
        else $error("refire queue overflow");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_fire |-> (r_valid[0] && out_free))
        else $error("fire pop without a due head or a free output");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop_fire || i_cmd.emit_close) |=> o_out_valid)
        else $error("emitted result not presented");

endmodule

// ===== sv/deadline_ordered_timer_queue.sv =====
`timescale 1ns / 1ps
// Top level of the deadline-ordered timer queue.
// Depends on dotq_pkg, dotq_ctrl and dotq_dp.
//
// Input channel: i_in_valid / o_in_stall with op, timer id, interval, repeat
// flag and the current time. Output channel: o_out_valid / i_out_stall.
// A transfer on the input starts one operation; the block then stalls its
// input until the closing result of that operation has been loaded.
// An add forms the saturated deadline and then inserts it, a cancel removes
// the first matching cell, an unused op code goes straight to its closing
// result, and a tick fires every due head, then reloads and reinserts each
// repeating timer from the refire queue. A tick fires at most one expired
// head per cycle while the output register is free, set by the single pop port
// of the sorted cell chain; each insert follows the saturated deadline step.
// Results are held in one output register: while the receiver stalls, the
// result holds and the operation waits. The next operation is accepted in
// the cycle after the closing result is loaded.
// Reset empties the queue and sets the stale delay to 100. The stale delay
// register may be written at any time the block is idle.
module deadline_ordered_timer_queue #(
    parameter int SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dotq_pkg::STALE_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [dotq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [dotq_pkg::IVAL_W-1:0]   i_interval_ms,
    input  logic                          i_repeat_req,
    input  logic [dotq_pkg::TIME_W-1:0]   i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [dotq_pkg::ID_W-1:0]     o_fired_id,
    output logic [1:0]                    o_status,
    output logic [dotq_pkg::IVAL_W-1:0]   o_next_wake_ms,
    output logic                          o_wake_pending,
    output logic                          o_last
);
    import dotq_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_sts sts_ctrl;

    always_comb begin
        sts_ctrl    = sts;
        sts_ctrl.op = t_op'(i_op);
    end

    dotq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts_ctrl),
        .o_cmd      (cmd)
    );

    dotq_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_op),
        .i_timer_id     (i_timer_id),
        .i_interval_ms  (i_interval_ms),
        .i_repeat_req   (i_repeat_req),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_fired_id     (o_fired_id),
        .o_status       (o_status),
        .o_next_wake_ms (o_next_wake_ms),
        .o_wake_pending (o_wake_pending),
        .o_last         (o_last)
    );

endmodule

// ===== tb/dotq_checker.sv =====
`timescale 1ns / 1ps
// Transfer monitor and scoreboard for the deadline-ordered timer queue.
// Depends on dotq_pkg; tracks the stale delay via the configuration port.
module dotq_checker #(
    parameter int SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dotq_pkg::STALE_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [dotq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [dotq_pkg::IVAL_W-1:0]   i_interval_ms,
    input  logic                          i_repeat_req,
    input  logic [dotq_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_kind,
    input  logic [dotq_pkg::ID_W-1:0]     i_fired_id,
    input  logic [1:0]                    i_status,
    input  logic [dotq_pkg::IVAL_W-1:0]   i_next_wake_ms,
    input  logic                          i_wake_pending,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending
);
    import dotq_pkg::*;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     fired_id;
        logic [1:0]          status;
        logic [IVAL_W-1:0]   wake;
        logic                pending;
        logic                last;
    } t_result;

    typedef struct {
        logic [TIME_W-1:0] deadline;
        logic [IVAL_W-1:0] period;
        logic              rearm;
        logic [ID_W-1:0]   ident;
    } t_timer;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    t_timer            timers[$];
    t_result           expected_results[$];
    logic [STALE_W-1:0] stale_delay;

    function automatic logic [TIME_W-1:0] due_time(logic [TIME_W-1:0] now,
                                                   logic [IVAL_W-1:0] period);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W + 1 - IVAL_W){1'b0}}, period};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic bit insert_sorted(t_timer t);
        int pos;
        if (timers.size() >= SLOTS) return 0;
        pos = timers.size();
        while (pos > 0 && timers[pos-1].deadline > t.deadline) pos--;
        timers.insert(pos, t);
        return 1;
    endfunction

    task automatic predict_operation(logic [1:0] op, logic [ID_W-1:0] id,
                                     logic [IVAL_W-1:0] ival, logic rearm,
                                     logic [TIME_W-1:0] now);
        t_timer  t;
        t_timer  fired[$];
        t_result r;
        logic [1:0] st;
        logic [TIME_W-1:0] diff;
        int hit;
        st = ST_OK;
        if (op == OP_ADD) begin
            t.deadline = due_time(now, ival);
            t.period = ival;
            t.rearm = rearm;
            t.ident = id;
            if (!insert_sorted(t)) st = ST_FULL;
        end else if (op == OP_CANCEL) begin
            hit = -1;
            foreach (timers[i]) if (hit < 0 && timers[i].ident == id) hit = i;
            if (hit < 0) st = ST_NOTFOUND;
            else timers.delete(hit);
        end else if (op == OP_TICK) begin
            while (timers.size() > 0 && timers[0].deadline <= now)
                fired.push_back(timers.pop_front());
            foreach (fired[i]) begin
                if (fired[i].rearm) begin
                    t = fired[i];
                    t.deadline = due_time(now, t.period);
                    void'(insert_sorted(t));
                end
            end
            foreach (fired[i]) begin
                r = '0;
                r.kind = KIND_FIRED;
                r.fired_id = fired[i].ident;
                expected_results.push_back(r);
            end
        end
        r = '0;
        r.kind = KIND_CLOSE;
        r.status = st;
        r.last = 1'b1;
        if (timers.size() > 0) begin
            r.pending = 1'b1;
            if (timers[0].deadline > now) begin
                diff = timers[0].deadline - now;
                r.wake = (diff > 48'hFFFF_FFFF) ? '1 : diff[IVAL_W-1:0];
            end else begin
                r.wake = IVAL_W'(stale_delay);
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            timers.delete();
            expected_results.delete();
            stale_delay <= STALE_RESET;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) stale_delay <= i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                got = '{i_kind, i_fired_id, i_status, i_next_wake_ms,
                        i_wake_pending, i_last};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch: expected %h actual %h",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_operation(i_op, i_timer_id, i_interval_ms, i_repeat_req,
                                  i_now_ms);
        end
        o_pending <= expected_results.size();
    end

    initial o_fail_count = 0;
    initial o_pending = 0;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the timer queue testbench: clock, reset, stimulus and verdict.
// Depends on dotq_pkg, deadline_ordered_timer_queue and dotq_checker.
module tb;
    import dotq_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [STALE_W-1:0]   cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           op = OP_NONE;
    logic [ID_W-1:0]      timer_id = '0;
    logic [IVAL_W-1:0]    interval_ms = '0;
    logic                 repeat_req = 1'b0;
    logic [TIME_W-1:0]    now_ms = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 kind;
    logic [ID_W-1:0]      fired_id;
    logic [1:0]           status;
    logic [IVAL_W-1:0]    next_wake_ms;
    logic                 wake_pending;
    logic                 last;
    int                   fail_count;
    int                   pending;
    int                   cycles = 0;
    logic [TIME_W-1:0]    clock_ms = '0;
    bit                   rx_quiet = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    deadline_ordered_timer_queue uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_op(op),
        .i_timer_id(timer_id), .i_interval_ms(interval_ms),
        .i_repeat_req(repeat_req), .i_now_ms(now_ms), .o_out_valid(out_valid),
        .i_out_stall(out_stall), .o_kind(kind), .o_fired_id(fired_id),
        .o_status(status), .o_next_wake_ms(next_wake_ms),
        .o_wake_pending(wake_pending), .o_last(last)
    );

    dotq_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_op(op),
        .i_timer_id(timer_id), .i_interval_ms(interval_ms),
        .i_repeat_req(repeat_req), .i_now_ms(now_ms), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_kind(kind), .i_fired_id(fired_id),
        .i_status(status), .i_next_wake_ms(next_wake_ms),
        .i_wake_pending(wake_pending), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    // After each transfer the receiver may stall at random, except while rx_quiet is set.
    always @(posedge i_clk) begin
        int wait_left;
        if (!i_rst_n) begin
            wait_left = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                wait_left = rx_quiet ? 0 : $urandom_range(0, 14);
            out_stall <= (wait_left > 0);
            if (wait_left > 0) wait_left--;
        end
    end

    task automatic send_op(logic [1:0] o, logic [ID_W-1:0] id, logic [IVAL_W-1:0] iv,
                           logic rep, logic [TIME_W-1:0] now, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        op <= o;
        timer_id <= id;
        interval_ms <= iv;
        repeat_req <= rep;
        now_ms <= now;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic write_stale(logic [STALE_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_op(bit quiet);
        int sel;
        logic [IVAL_W-1:0] iv;
        logic [1:0] o;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: iv = $urandom_range(0, 3);
            1: iv = $urandom_range(0, 200);
            2: iv = $urandom();
            default: iv = $urandom_range(0, 60);
        endcase
        if (sel < 45) o = OP_ADD;
        else if (sel < 63) o = OP_CANCEL;
        else if (sel < 97) o = OP_TICK;
        else o = OP_NONE;
        if (o == OP_TICK) clock_ms = clock_ms + TIME_W'($urandom_range(0, 80));
        send_op(o, 8'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255)),
                iv, 1'($urandom_range(0, 1)), clock_ms, quiet ? 0 : $urandom_range(0, 14));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed part: extremes, full queue, missing cancel, saturation.
        send_op(OP_TICK, 8'd0, '0, 1'b0, '0, 0);
        send_op(OP_CANCEL, 8'd5, '0, 1'b0, '0, 0);
        send_op(OP_ADD, 8'hFF, '1, 1'b1, '1, 1);
        send_op(OP_ADD, 8'h00, 32'd0, 1'b1, 48'd10, 0);
        send_op(OP_ADD, 8'hAA, '1, 1'b0, 48'd10, 0);
        send_op(OP_TICK, 8'd0, '0, 1'b0, 48'd10, 0);
        send_op(OP_NONE, 8'h55, 32'h5555_5555, 1'b1, 48'h5555_5555_5555, 0);
        for (int i = 0; i < 16; i++)
            send_op(OP_ADD, 8'(i), 32'(i % 3), 1'(i % 2), 48'd20, 0);
        send_op(OP_CANCEL, 8'h77, '0, 1'b0, 48'd20, 0);
        send_op(OP_TICK, 8'd0, '0, 1'b0, 48'hFFFF_FFFF_FFFF, 0);
        send_op(OP_CANCEL, 8'hFF, '0, 1'b0, 48'hFFFF_FFFF_FFFF, 0);
        write_stale(16'hFFFF);
        send_op(OP_TICK, 8'd0, '0, 1'b0, 48'hFFFF_FFFF_FFFF, 0);
        for (int i = 0; i < 16; i++)
            send_op(OP_CANCEL, 8'(i), '0, 1'b0, '0, 0);
        write_stale(16'd0);
        clock_ms = 48'd30;
        for (int phase = 0; phase < 4; phase++) begin
            rx_quiet = (phase == 2);
            for (int n = 0; n < 70; n++) random_op(phase == 2);
            case (phase)
                0: write_stale(16'd1);
                1: write_stale(16'($urandom_range(1, 65535)));
                default: write_stale(16'd100);
            endcase
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/dotq_pkg.sv
sv/dotq_ctrl.sv
sv/dotq_dp.sv
sv/deadline_ordered_timer_queue.sv
tb/dotq_checker.sv
tb/tb.sv
